[design/abds_pkg.sv]
// Shared types, constants and helper functions for the archive byte stream
// decrypt unit. No dependencies; every other design file uses this package.
`default_nettype none

package abds_pkg;

  // Field widths
  localparam int unsigned KEY_WORD_W = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned STR_W      = 7;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;

  // Boundary constants of the position stepping rule
  localparam logic [POS_W:0]   POS_A_LAST   = 5'h0F;
  localparam logic [POS_W:0]   POS_B_WRAP   = 5'h0C;
  localparam logic [POS_W:0]   POS_B_SPLIT  = 5'h08;
  localparam logic [POS_W-1:0] POS_A_INIT   = 4'd0;
  localparam logic [POS_W-1:0] POS_B_INIT   = 4'd8;
  localparam logic [STR_W-1:0] STR_STEP     = 7'd2;
  localparam logic [POS_W-1:0] POS_B_RELOAD = 4'd2;
  localparam logic [POS_W-1:0] POS_A_RELOAD = 4'd3;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DECRYPT = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_SKIP    = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A_LOW    = 3'd0,
    CFG_KEY_A_HIGH   = 3'd1,
    CFG_KEY_B_LOW    = 3'd2,
    CFG_KEY_B_HIGH   = 3'd3,
    CFG_START_STRING = 3'd4,
    CFG_ENABLE       = 3'd5
  } cfg_idx_t;

  // Cipher state carried between the top level and the step logic
  typedef struct packed {
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [STR_W-1:0] str_num;
    logic             swap;
  } state_t;

  // 5-bit value mod 3: fold base-4 digits, then one compare and subtract
  function automatic logic [1:0] mod3_5b(input logic [4:0] m);
    logic [2:0] s;
    logic [2:0] t;
    s = {2'b00, m[4]} + {1'b0, m[3:2]} + {1'b0, m[1:0]};
    t = {2'b00, s[2]} + {1'b0, s[1:0]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // 7-bit value mod 7: fold base-8 digits twice, then one compare and subtract
  function automatic logic [2:0] mod7_7b(input logic [STR_W-1:0] n);
    logic [3:0] s;
    logic [3:0] t;
    s = {3'b000, n[6]} + {1'b0, n[5:3]} + {1'b0, n[2:0]};
    t = {3'b000, s[3]} + {1'b0, s[2:0]};
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  // 7-bit value mod 12: low two bits pass, the rest is taken mod 3
  function automatic logic [3:0] mod12_7b(input logic [STR_W-1:0] n);
    return {mod3_5b(n[6:2]), n[1:0]};
  endfunction

endpackage

`default_nettype wire

[design/abds_ifs.sv]
// Handshake channel interfaces: encrypted byte requests, plain byte results
// and configuration writes. Depends on abds_pkg for field widths.
`default_nettype none

interface abds_enc_if;
  logic                              valid;
  logic                              ready;
  logic [abds_pkg::KIND_W-1:0]       kind;
  logic [abds_pkg::BYTE_W-1:0]       data_byte;
  logic                              end_of_read;

  modport source (output valid, kind, data_byte, end_of_read, input ready);
  modport sink   (input valid, kind, data_byte, end_of_read, output ready);
endinterface

interface abds_dec_if;
  logic                              valid;
  logic                              ready;
  logic [abds_pkg::BYTE_W-1:0]       plain_byte;
  logic                              end_of_read_out;

  modport source (output valid, plain_byte, end_of_read_out, input ready);
  modport sink   (input valid, plain_byte, end_of_read_out, output ready);
endinterface

interface abds_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [abds_pkg::CFG_IDX_W-1:0]    index;
  logic [abds_pkg::KEY_WORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/archive_byte_stream_decrypt_unit.sv]
// Archive byte stream decrypt unit. Takes one request per cycle (decrypt a
// byte, restart the cipher state from the configured start string number, or
// skip one byte position) and gives one plain byte per decrypt request, in
// order, through the input register and then the result register.
// Throughput is one request every clock: a request is held in an input
// register, then the key-byte selects, the nibble swap and the state step
// (mod 7 / mod 12 by digit folding) settle combinationally into the result
// register and the state registers. The input side stalls only while a
// result waits in the output register and the next stage also holds a decrypt
// request. Configuration (two 16-byte keys, start string number, enable) is
// written through the cfg channel, which is always ready, and must only be
// changed while no requests are in flight. With decryption off, bytes pass
// through; only restarts change state. Uses abds_pkg, abds_ifs, abds_step.
`default_nettype none

module archive_byte_stream_decrypt_unit (
  input  wire        clk,
  input  wire        rst,
  abds_enc_if.sink   enc,
  abds_dec_if.source dec,
  abds_cfg_if.sink   cfg
);
  import abds_pkg::*;

  // Configuration registers
  logic [KEY_WORD_W-1:0]   key_a_low;
  logic [KEY_WORD_W-1:0]   key_a_high;
  logic [KEY_WORD_W-1:0]   key_b_low;
  logic [KEY_WORD_W-1:0]   key_b_high;
  logic [STR_W-1:0]        start_string_number;
  logic                    decrypt_enable;

  // Input stage
  logic                    s1_valid;
  logic [KIND_W-1:0]       s1_kind;
  logic [BYTE_W-1:0]       s1_data;
  logic                    s1_eor;

  // Cipher state
  state_t                  state;
  state_t                  state_next;
  state_t                  stepped;

  // Result register
  logic                    out_valid;
  logic [BYTE_W-1:0]       out_byte;
  logic                    out_eor;

  logic                    out_free;
  logic                    s1_has_result;
  logic                    s1_go;
  logic [2*KEY_WORD_W-1:0] key_a;
  logic [2*KEY_WORD_W-1:0] key_b;
  logic [BYTE_W-1:0]       kb;
  logic [BYTE_W-1:0]       ka;
  logic [BYTE_W-1:0]       mixed;
  logic [BYTE_W-1:0]       swapped;
  logic [BYTE_W-1:0]       result_byte;

  // Handshake control
  assign out_free      = ~out_valid | dec.ready;
  assign s1_has_result = (s1_kind == KIND_DECRYPT);
  assign s1_go         = s1_valid & (~s1_has_result | out_free);
  assign enc.ready     = ~s1_valid | s1_go;
  assign cfg.ready     = 1'b1;

  assign dec.valid           = out_valid;
  assign dec.plain_byte      = out_byte;
  assign dec.end_of_read_out = out_eor;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a_low           <= '0;
      key_a_high          <= '0;
      key_b_low           <= '0;
      key_b_high          <= '0;
      start_string_number <= '0;
      decrypt_enable      <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_KEY_A_LOW:    key_a_low           <= cfg.data;
        CFG_KEY_A_HIGH:   key_a_high          <= cfg.data;
        CFG_KEY_B_LOW:    key_b_low           <= cfg.data;
        CFG_KEY_B_HIGH:   key_b_high          <= cfg.data;
        CFG_START_STRING: start_string_number <= cfg.data[STR_W-1:0];
        CFG_ENABLE:       decrypt_enable      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Capture an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (enc.ready) begin
      s1_valid <= enc.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enc.ready) begin
      s1_kind <= enc.kind;
      s1_data <= enc.data_byte;
      s1_eor  <= enc.end_of_read;
    end
  end

  // Decrypt the held byte
  assign key_a   = {key_a_high, key_a_low};
  assign key_b   = {key_b_high, key_b_low};
  assign kb      = key_b[state.pos_b*BYTE_W +: BYTE_W];
  assign ka      = key_a[state.pos_a*BYTE_W +: BYTE_W];
  assign mixed   = s1_data ^ kb ^ {1'b0, state.str_num};
  assign swapped = state.swap ? {mixed[3:0], mixed[7:4]} : mixed;
  assign result_byte = decrypt_enable ? (swapped ^ ka) : s1_data;

  abds_step u_step (
    .cur (state),
    .nxt (stepped)
  );

  // Select the next cipher state for the request in flight
  always_comb begin
    state_next = state;
    case (s1_kind)
      KIND_RESTART: begin
        state_next.pos_a   = POS_A_INIT;
        state_next.pos_b   = POS_B_INIT;
        state_next.str_num = start_string_number;
        state_next.swap    = 1'b0;
      end
      KIND_SKIP, KIND_DECRYPT: begin
        if (decrypt_enable) begin
          state_next = stepped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.pos_a   <= POS_A_INIT;
      state.pos_b   <= POS_B_INIT;
      state.str_num <= '0;
      state.swap    <= 1'b0;
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_has_result) begin
      out_valid <= 1'b1;
    end else if (dec.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_result) begin
      out_byte <= result_byte;
      out_eor  <= s1_eor;
    end
  end

endmodule

`default_nettype wire

[design/abds_step.sv]
// Position and string-number stepping rule applied after each byte.
// Pure combinational; depends on abds_pkg for state_t and the mod helpers.
`default_nettype none

module abds_step (
  input  wire abds_pkg::state_t cur,
  output abds_pkg::state_t      nxt
);
  import abds_pkg::*;

  logic [POS_W:0]   a_inc;
  logic [POS_W:0]   b_inc;
  logic [STR_W-1:0] n;
  logic [POS_W-1:0] n_mod7;
  logic [POS_W-1:0] n_mod12;

  assign a_inc   = {1'b0, cur.pos_a} + {{POS_W{1'b0}}, 1'b1};
  assign b_inc   = {1'b0, cur.pos_b} + {{POS_W{1'b0}}, 1'b1};
  assign n       = cur.str_num + STR_STEP;
  assign n_mod7  = {1'b0, mod7_7b(n)};
  assign n_mod12 = mod12_7b(n);

  // Pick one of the three boundary rules
  always_comb begin
    nxt = cur;
    if (a_inc <= POS_A_LAST) begin
      nxt.pos_a = a_inc[POS_W-1:0];
      if (b_inc > POS_B_WRAP) begin
        nxt.pos_b = '0;
        nxt.swap  = ~cur.swap;
      end else begin
        nxt.pos_b = b_inc[POS_W-1:0];
      end
    end else if (b_inc <= POS_B_SPLIT) begin
      nxt.pos_a = '0;
      nxt.pos_b = b_inc[POS_W-1:0];
      nxt.swap  = ~cur.swap;
    end else begin
      nxt.str_num = n;
      if (cur.swap) begin
        nxt.pos_a = n_mod7;
        nxt.pos_b = n_mod12 + POS_B_RELOAD;
        nxt.swap  = 1'b0;
      end else begin
        nxt.pos_b = n_mod7;
        nxt.pos_a = n_mod12 + POS_A_RELOAD;
        nxt.swap  = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/abds_checker.sv]
// Port-level checks for the archive byte stream decrypt unit, and the bind
// that attaches them to the top level. Depends on abds_pkg for widths.
`default_nettype none

module abds_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          enc_ready,
  input wire                          dec_valid,
  input wire                          dec_ready,
  input wire [abds_pkg::BYTE_W-1:0]   dec_plain_byte,
  input wire                          dec_end_of_read_out,
  input wire                          cfg_ready
);
  import abds_pkg::*;

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !dec_valid)
    else $error("result valid after reset");

  // Reset empties the input stage, so requests are taken right away
  assert property (@(posedge clk) rst |=> enc_ready)
    else $error("request side stalled after reset");

  // Request side only stalls behind a waiting, untaken result, and cfg stays ready
  assert property (@(posedge clk) disable iff (rst)
    !enc_ready |-> (dec_valid && !dec_ready) && cfg_ready)
    else $error("request stall without a blocked result");

  // A stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec_plain_byte)
      && $stable(dec_end_of_read_out))
    else $error("stalled result changed or dropped");

endmodule

bind archive_byte_stream_decrypt_unit abds_checker u_abds_checker (
  .clk                 (clk),
  .rst                 (rst),
  .enc_ready           (enc.ready),
  .dec_valid           (dec.valid),
  .dec_ready           (dec.ready),
  .dec_plain_byte      (dec.plain_byte),
  .dec_end_of_read_out (dec.end_of_read_out),
  .cfg_ready           (cfg.ready)
);

`default_nettype wire
